>>> sv/pwrg_pkg.sv
// Types, constants and the Q1.15 rounding function shared by the plane wave generator.
`timescale 1ns / 1ps

package pwrg_pkg;

    // Input beat: one signed pixel coordinate pair
    typedef struct packed {
        logic signed [7:0] x_coord;
        logic signed [7:0] y_coord;
    } pixel_t;

    // Output beat: one complex Q1.15 sample
    typedef struct packed {
        logic signed [15:0] real_part;
        logic signed [15:0] imag_part;
    } sample_t;

    // Configuration register file
    typedef struct packed {
        logic              wave_mode;
        logic signed [7:0]  wave_x;
        logic signed [7:0]  wave_y;
        logic signed [15:0] scale_a;
        logic signed [15:0] scale_b;
    } cfg_t;

    // Register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_B   = 3'd4;

    // Mode codes
    localparam logic MODE_MAG_PHASE = 1'b0;
    localparam logic MODE_FIXED_DIR = 1'b1;

    // Angle reduction modulo 360 degrees
    localparam logic [8:0]  DEG_PER_TURN = 9'd360;
    localparam int          DEG_W        = 9;
    localparam logic [16:0] ANGLE_OFFSET = 17'd33120;  // 92 turns, makes the angle positive
    localparam logic [17:0] MOD_RECIP    = 18'd186414; // ceil(2^26 / 360)
    localparam int          MOD_SHIFT    = 26;
    localparam int          MOD_PROD_W   = 35;

    // Index-to-phase reciprocal multiply, split over two stages
    localparam int PHASE_W      = 32;
    localparam int PHASE_STAGES = 2;

    // CORDIC rotator
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam logic [31:0] CORDIC_START = 32'd652032874;
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Pipeline depths
    localparam int FRONT_LAT  = 6;
    localparam int PHASE_LAT  = FRONT_LAT + PHASE_STAGES;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int TOTAL_LAT  = PHASE_LAT + 2 * CORDIC_LAT + 3;

    // Rounding width for Q2.30 values
    localparam int Q_W = 40;

    // Round a 2^30-scaled value to Q1.15: add half, floor shift, saturate
    function automatic logic signed [15:0] to_q15(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] r;
        r = (v + Q_W'(16384)) >>> 15;
        if (r > Q_W'(32767)) begin
            return 16'sh7FFF;
        end
        if (r < -Q_W'(32768)) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

endpackage

>>> sv/pwrg_phase.sv
// Pixel coordinate to ROM phase: angle, modulo 360, table index and phase division.
`timescale 1ns / 1ps

module pwrg_phase #(
    parameter int COS_TABLE_ENTRIES = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pwrg_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  pwrg_pkg::pixel_t pixel,
    output logic             out_valid,
    output logic [31:0]      phase
);
    import pwrg_pkg::*;

    localparam int IW = $clog2(COS_TABLE_ENTRIES);
    localparam int NW = $clog2(360 * COS_TABLE_ENTRIES);
    localparam int K  = NW + DEG_W;
    localparam longint unsigned IDX_RECIP = ((64'd1 << K) + 64'd359) / 64'd360;
    localparam int MW = $clog2(IDX_RECIP + 1);
    localparam int PW = NW + MW;

    // ceil(2^(32+PK) / entries): exact quotient for every idx below entries
    localparam int PK = 2 * IW;
    localparam longint unsigned PH_RECIP =
        ((64'hFFFF_FFFF_FFFF_FFFF >> (32 - PK)) / 64'(COS_TABLE_ENTRIES)) + 64'd1;
    localparam int RW = $clog2(PH_RECIP + 1);
    localparam int RL = 24;
    localparam int RH = RW - RL;
    localparam int TW = IW + RW;
    localparam logic [RL-1:0] RECIP_LO = RL'(PH_RECIP);
    localparam logic [RH-1:0] RECIP_HI = RH'(PH_RECIP >> RL);

    logic [PHASE_LAT-1:0]      fv_reg;
    logic signed [15:0]        px_reg, py_reg;
    logic [16:0]               a_reg, a3_reg;
    logic [MOD_PROD_W-1:0]     aq_reg;
    logic [DEG_W-1:0]          r_reg;
    logic [NW-1:0]             rn_reg;
    logic [PW-1:0]             rm_reg;
    logic signed [17:0]        sum;
    logic [DEG_W-1:0]          q;
    logic [16:0]               qm;
    logic [DEG_W-1:0]          r_next;

    logic [IW-1:0]             idx;
    logic [IW+RL-1:0]          plo_reg;
    logic [IW+RH-1:0]          phi_reg;
    logic [TW-1:0]             prod;
    logic [PHASE_W-1:0]        phase_reg;

    // Angle sum made positive, then modulo 360 by reciprocal multiply
    always_comb
    begin
        sum    = 18'(px_reg) + 18'(py_reg) + 18'(ANGLE_OFFSET);
        q      = aq_reg[MOD_PROD_W-1:MOD_SHIFT];
        qm     = 17'(q) * 17'(DEG_PER_TURN);
        r_next = DEG_W'(a3_reg - qm);
    end

    // Valid bits for every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else
        begin
            fv_reg <= {fv_reg[PHASE_LAT-2:0], in_valid};
        end
    end

    // Front stages: products, angle, reduction, index
    always_ff @(posedge clk)
    begin
        px_reg <= cfg.wave_x * pixel.x_coord;
        py_reg <= cfg.wave_y * pixel.y_coord;
        a_reg  <= sum[16:0];
        a3_reg <= a_reg;
        aq_reg <= MOD_PROD_W'(a_reg) * MOD_PROD_W'(MOD_RECIP);
        r_reg  <= r_next;
        rn_reg <= NW'(r_reg) * NW'(COS_TABLE_ENTRIES);
        rm_reg <= PW'(rn_reg) * PW'(IDX_RECIP);
    end

    // Phase = floor(idx * 2^32 / entries): partial products, then sum and shift
    always_comb
    begin
        idx  = rm_reg[K +: IW];
        prod = {phi_reg, {RL{1'b0}}} + TW'(plo_reg);
    end

    always_ff @(posedge clk)
    begin
        plo_reg   <= (IW + RL)'(idx) * (IW + RL)'(RECIP_LO);
        phi_reg   <= (IW + RH)'(idx) * (IW + RH)'(RECIP_HI);
        phase_reg <= prod[PK +: PHASE_W];
    end

    assign out_valid = fv_reg[PHASE_LAT-1];
    assign phase     = phase_reg;

    // Checks
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, PHASE_LAT))
        else $error("phase beat without matching input beat");
    a_mod: assert property (@(posedge clk) disable iff (!rst_n)
        fv_reg[3] |-> (r_reg < DEG_PER_TURN))
        else $error("angle reduction left a value of 360 or more");

endmodule

>>> sv/pwrg_cordic.sv
// Pipelined CORDIC: 32-bit turn phase to Q1.15 cosine and sine, one step per stage.
`timescale 1ns / 1ps

module pwrg_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [31:0]         phase,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic signed [15:0]  cos_out,
    output logic signed [15:0]  sin_out,
    output logic [SIDE_W-1:0]   side_out
);
    import pwrg_pkg::*;

    logic [CORDIC_STEPS:0]         v_reg;
    logic signed [CORDIC_W-1:0]    x_reg    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0]    y_reg    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0]    z_reg    [0:CORDIC_STEPS];
    logic [1:0]                    quad_reg [0:CORDIC_STEPS];
    logic [SIDE_W-1:0]             side_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0]    x_next   [0:CORDIC_STEPS-1];
    logic signed [CORDIC_W-1:0]    y_next   [0:CORDIC_STEPS-1];
    logic signed [CORDIC_W-1:0]    z_next   [0:CORDIC_STEPS-1];

    logic signed [CORDIC_W-1:0]    c_full, s_full;
    logic                          out_valid_reg;
    logic signed [15:0]            cos_reg, sin_reg;
    logic [SIDE_W-1:0]             side_out_reg;

    // Entry stage: start vector and quadrant split
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CORDIC_W'(CORDIC_START);
        y_reg[0]    <= '0;
        z_reg[0]    <= CORDIC_W'(phase[29:0]);
        quad_reg[0] <= phase[31:30];
        side_reg[0] <= side_in;
    end

    // Rotation steps
    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            always_comb
            begin
                if (!z_reg[i][CORDIC_W-1])
                begin
                    x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                    y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                    z_next[i] = z_reg[i] - $signed(CORDIC_W'(ATAN_TURNS[i]));
                end
                else
                begin
                    x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                    y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                    z_next[i] = z_reg[i] + $signed(CORDIC_W'(ATAN_TURNS[i]));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else
                begin
                    v_reg[i+1] <= v_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                z_reg[i+1]    <= z_next[i];
                quad_reg[i+1] <= quad_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    endgenerate

    // Quadrant fold, exact
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            2'd0:
            begin
                c_full = x_reg[CORDIC_STEPS];
                s_full = y_reg[CORDIC_STEPS];
            end
            2'd1:
            begin
                c_full = -y_reg[CORDIC_STEPS];
                s_full = x_reg[CORDIC_STEPS];
            end
            2'd2:
            begin
                c_full = -x_reg[CORDIC_STEPS];
                s_full = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                c_full = y_reg[CORDIC_STEPS];
                s_full = -x_reg[CORDIC_STEPS];
            end
        endcase
    end

    // Output stage: round to Q1.15
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg      <= to_q15(Q_W'(c_full));
        sin_reg      <= to_q15(Q_W'(s_full));
        side_out_reg <= side_reg[CORDIC_STEPS];
    end

    assign out_valid = out_valid_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;
    assign side_out  = side_out_reg;

    // Checks
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, CORDIC_LAT))
        else $error("CORDIC beat without matching input beat");

endmodule

>>> sv/plane_wave_raster_generator.sv
// Plane wave raster generator: top level with register file, modulation and output stage.
`timescale 1ns / 1ps

// Usage
//   Input beat: drive pixel (x_coord, y_coord) and raise start; the beat is taken at a
//   rising edge where start is high and busy is low. busy is high in reset and until the
//   first edge after reset release, so one beat can be taken on every clock from then on.
//   Output beat: done is high for exactly one cycle with the sample on sample
//   (real_part, imag_part, Q1.15). The receiver cannot stall; results come in input order.
//   Throughput: one pixel per clock. The depth is set by the two 26-stage CORDIC
//   pipelines (the cosine lookup and the mode 0 phase rotation) plus the 8-stage
//   angle reduction and index-to-phase front end.
//   Configuration: cfg_we, cfg_index, cfg_data write one register per edge. Index 0 mode,
//   1 wave_x, 2 wave_y, 3 scale_a, 4 scale_b; other indexes are ignored. Write only while
//   no beat is in flight.
//   Reset: rst_n clears the registers to zero and empties the pipeline; beats in flight
//   are dropped and no done pulse follows them.
module plane_wave_raster_generator #(
    parameter int COS_TABLE_ENTRIES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  pwrg_pkg::pixel_t                     pixel,
    output logic                                 done,
    output pwrg_pkg::sample_t                    sample,
    input  logic                                 cfg_we,
    input  logic [pwrg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pwrg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pwrg_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    logic               busy_reg;
    logic               accept;

    logic               ph_valid;
    logic [31:0]        ph;
    logic               c1_valid;
    logic signed [15:0] c1_cos;

    logic               m1_valid_reg;
    logic signed [31:0] pa_reg, pb_reg;
    logic signed [15:0] mag, im1;

    logic               c2_valid;
    logic signed [15:0] c2_cos, c2_sin;
    logic [31:0]        c2_side;
    logic signed [15:0] mag2, im2;

    logic               p_valid_reg;
    logic signed [31:0] pr_reg, pi_reg;
    logic signed [15:0] mag_p_reg, im1_p_reg;

    logic               done_reg;
    sample_t            sample_reg, sample_next;

    // Register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WAVE_MODE: cfg_next.wave_mode = cfg_data[0];
                REG_WAVE_X:    cfg_next.wave_x    = cfg_data[7:0];
                REG_WAVE_Y:    cfg_next.wave_y    = cfg_data[7:0];
                REG_SCALE_A:   cfg_next.scale_a   = cfg_data;
                REG_SCALE_B:   cfg_next.scale_b   = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // Angle to ROM phase
    pwrg_phase #(
        .COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (accept),
        .pixel     (pixel),
        .out_valid (ph_valid),
        .phase     (ph)
    );

    // Cosine lookup
    pwrg_cordic #(
        .SIDE_W(1)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .phase     (ph),
        .side_in   (1'b0),
        .out_valid (c1_valid),
        .cos_out   (c1_cos),
        .sin_out   (),
        .side_out  ()
    );

    // Scale products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= c1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= c1_cos * cfg_reg.scale_a;
        pb_reg <= c1_cos * cfg_reg.scale_b;
    end

    assign mag = to_q15(Q_W'(pa_reg));
    assign im1 = to_q15(Q_W'(pb_reg));

    // Phase rotation; Q2.30 product wraps as a turn fraction
    pwrg_cordic #(
        .SIDE_W(32)
    ) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m1_valid_reg),
        .phase     ($unsigned(pb_reg)),
        .side_in   ({mag, im1}),
        .out_valid (c2_valid),
        .cos_out   (c2_cos),
        .sin_out   (c2_sin),
        .side_out  (c2_side)
    );

    assign mag2 = c2_side[31:16];
    assign im2  = c2_side[15:0];

    // Magnitude times rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg    <= mag2 * c2_cos;
        pi_reg    <= mag2 * c2_sin;
        mag_p_reg <= mag2;
        im1_p_reg <= im2;
    end

    // Output select and register
    always_comb
    begin
        if (cfg_reg.wave_mode == MODE_FIXED_DIR)
        begin
            sample_next.real_part = mag_p_reg;
            sample_next.imag_part = im1_p_reg;
        end
        else
        begin
            sample_next.real_part = to_q15(Q_W'(pr_reg));
            sample_next.imag_part = to_q15(Q_W'(pi_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign done   = done_reg;
    assign sample = sample_reg;

    // Checks
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, TOTAL_LAT))
        else $error("result beat without an accepted input beat");
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("accepted input beat produced no result");
    a_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cfg_reg.wave_mode == MODE_MAG_PHASE && cfg_reg.scale_a == 16'sd0)
            |-> (sample.real_part == 16'sd0 && sample.imag_part == 16'sd0))
        else $error("zero magnitude gave a nonzero sample");
    a_zero_imag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cfg_reg.wave_mode == MODE_FIXED_DIR && cfg_reg.scale_b == 16'sd0)
            |-> (sample.imag_part == 16'sd0))
        else $error("zero imaginary scale gave a nonzero imaginary part");

endmodule

>>> sim/plane_wave_raster_generator_tb.sv
// Self-checking testbench for the plane wave raster generator: predicts every sample.
`timescale 1ns / 1ps

module plane_wave_raster_generator_tb;

    import pwrg_pkg::*;

    localparam int COS_ENTRIES = 1024;
    localparam int PIPE_DRAIN  = 80;          // longer than the pipeline latency
    localparam int SWEEP_ITEMS = 40;
    localparam int SWEEPS      = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_SCALE_B + 1'b1;

    // arctangents of 2^-i in units of 2^-32 turn
    localparam longint ROT_ANGLE [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };
    localparam longint ROT_START = 64'd652032874;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    pixel_t                pixel;
    logic                  done;
    sample_t               sample;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    plane_wave_raster_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pixels waiting to go in, samples waiting to come out
    pixel_t  pixel_backlog[$];
    sample_t sample_due[$];

    // Shadow copy of the register file
    logic              sh_mode;
    logic signed [7:0]  sh_wave_x;
    logic signed [7:0]  sh_wave_y;
    logic signed [15:0] sh_scale_a;
    logic signed [15:0] sh_scale_b;

    int  gap_left;
    bit  gaps_on;
    int  gap_pct;
    int  mismatches;
    int  beats_in;
    int  beats_out;
    int  cfg_writes;
    int  mode0_sweeps;
    int  mode1_sweeps;

    always #5 clk = ~clk;

    // Q2.30 to Q1.15: add half an LSB, floor shift, saturate
    function automatic logic signed [15:0] sat_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end else if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return r[15:0];
    endfunction

    // 24-step rotator on a 32-bit turn fraction; quadrant from the top two bits
    function automatic void turn_sincos(input logic [31:0] phase,
                                        output logic signed [15:0] cos_q,
                                        output logic signed [15:0] sin_q);
        longint rx, ry, rz, dx, dy, c, s;
        rx = ROT_START;
        ry = 0;
        rz = {34'd0, phase[29:0]};
        for (int i = 0; i < 24; i++) begin
            dx = ry >>> i;
            dy = rx >>> i;
            if (rz >= 0) begin
                rx = rx - dx;
                ry = ry + dy;
                rz = rz - ROT_ANGLE[i];
            end else begin
                rx = rx + dx;
                ry = ry - dy;
                rz = rz + ROT_ANGLE[i];
            end
        end
        case (phase[31:30])
            2'd0: begin c = rx;  s = ry;  end
            2'd1: begin c = -ry; s = rx;  end
            2'd2: begin c = -rx; s = -ry; end
            default: begin c = ry; s = -rx; end
        endcase
        cos_q = sat_q15(c);
        sin_q = sat_q15(s);
    endfunction

    // Expected sample for one pixel under the shadow registers
    function automatic sample_t wave_sample(input pixel_t p);
        int                 angle;
        int                 deg;
        longint             rom_phase;
        longint             prod;
        logic signed [15:0] v, unused_sin, mag, c, s;
        sample_t            o;
        angle = int'(sh_wave_x) * int'(p.x_coord) + int'(sh_wave_y) * int'(p.y_coord);
        deg = angle % 360;
        if (deg < 0) begin
            deg = deg + 360;
        end
        rom_phase = (longint'((deg * COS_ENTRIES) / 360) << 32) / COS_ENTRIES;
        turn_sincos(rom_phase[31:0], v, unused_sin);
        if (sh_mode == MODE_FIXED_DIR) begin
            o.real_part = sat_q15(longint'(v) * longint'(sh_scale_a));
            o.imag_part = sat_q15(longint'(v) * longint'(sh_scale_b));
        end else begin
            mag  = sat_q15(longint'(v) * longint'(sh_scale_a));
            prod = longint'(v) * longint'(sh_scale_b);
            turn_sincos(prod[31:0], c, s);
            o.real_part = sat_q15(longint'(mag) * longint'(c));
            o.imag_part = sat_q15(longint'(mag) * longint'(s));
        end
        return o;
    endfunction

    // Driver: presents the oldest pending pixel, with random gap bursts
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pixel_backlog.size() == 0) begin
            start <= 1'b0;
        end else if (gaps_on && $urandom_range(99) < gap_pct) begin
            start    <= 1'b0;
            gap_left <= $urandom_range(17, 1) - 1;
        end else begin
            start <= 1'b1;
            pixel <= pixel_backlog[0];
        end
    end

    // Monitor: mirrors register writes, predicts accepted beats, checks output beats
    always @(posedge clk) begin
        sample_t want;
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_WAVE_MODE: sh_mode    <= cfg_data[0];
                    REG_WAVE_X:    sh_wave_x  <= cfg_data[7:0];
                    REG_WAVE_Y:    sh_wave_y  <= cfg_data[7:0];
                    REG_SCALE_A:   sh_scale_a <= cfg_data;
                    REG_SCALE_B:   sh_scale_b <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                sample_due.push_back(wave_sample(pixel));
                void'(pixel_backlog.pop_front());
                beats_in++;
            end
            if (done) begin
                beats_out++;
                if (sample_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected sample re=%0d im=%0d", $realtime,
                                 sample.real_part, sample.imag_part);
                    end
                end else begin
                    want = sample_due.pop_front();
                    if (sample.real_part !== want.real_part
                        || sample.imag_part !== want.imag_part) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: sample %0d expected re=%0d im=%0d got re=%0d im=%0d",
                                     $realtime, beats_out, want.real_part, want.imag_part,
                                     sample.real_part, sample.imag_part);
                        end
                    end
                end
            end
        end
    end

    // One register write beat; upper data bits carry noise where the register is narrow
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // Field value of width w, biased toward min, max, zero and minus one
    function automatic logic [15:0] pick_field(input int w);
        int unsigned noise, mask, v;
        noise = $urandom;
        mask  = (32'd1 << w) - 1;
        case ($urandom_range(7))
            0: v = (noise & ~mask) | (32'd1 << (w - 1));
            1: v = (noise & ~mask) | ((32'd1 << (w - 1)) - 1);
            2: v = noise & ~mask;
            3: v = noise | mask;
            default: v = noise;
        endcase
        return v[15:0];
    endfunction

    task automatic set_all(input logic mode, input logic [15:0] wx, input logic [15:0] wy,
                           input logic [15:0] sa, input logic [15:0] sb);
        write_reg(REG_WAVE_MODE, {15'($urandom_range(32767)), mode});
        write_reg(REG_WAVE_X, wx);
        write_reg(REG_WAVE_Y, wy);
        write_reg(REG_SCALE_A, sa);
        write_reg(REG_SCALE_B, sb);
        if (mode == MODE_FIXED_DIR) begin
            mode1_sweeps++;
        end else begin
            mode0_sweeps++;
        end
    endtask

    task automatic add_pixel(input logic [7:0] x, input logic [7:0] y);
        pixel_t p;
        p.x_coord = x;
        p.y_coord = y;
        pixel_backlog.push_back(p);
    endtask

    // Block until every pixel went in and every sample came out
    task automatic drain();
        while (pixel_backlog.size() != 0 || sample_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Stimulus
    initial begin
        logic [7:0] row, col;
        int         run_len;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        pixel      = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        gap_left   = 0;
        gaps_on    = 1'b1;
        gap_pct    = 20;
        sh_mode    = MODE_MAG_PHASE;
        sh_wave_x  = '0;
        sh_wave_y  = '0;
        sh_scale_a = '0;
        sh_scale_b = '0;
        mismatches = 0;
        beats_in   = 0;
        beats_out  = 0;
        cfg_writes = 0;
        mode0_sweeps = 0;
        mode1_sweeps = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers at reset value: all samples zero
        @(posedge clk);
        add_pixel(8'h80, 8'h7F);
        add_pixel(8'h05, 8'hFB);
        drain();

        // Fixed direction, cosine of -1 times -1.0 saturates; exact pixel positions
        set_all(MODE_FIXED_DIR, 16'hAB5A, 16'h0000, 16'h8000, 16'h7FFF);
        @(posedge clk);
        add_pixel(8'd2, 8'd0);      // 180 degrees
        add_pixel(8'd0, 8'd0);
        add_pixel(8'd1, 8'd0);
        add_pixel(8'hFF, 8'd0);
        add_pixel(8'd4, 8'd0);      // full turn
        add_pixel(8'h80, 8'h80);
        add_pixel(8'h7F, 8'h7F);
        drain();

        // Magnitude and phase at the register extremes, spare indexes ignored
        set_all(MODE_MAG_PHASE, 16'h007F, 16'hFF80, 16'h7FFF, 16'h8000);
        write_reg(REG_SPARE_FIRST, 16'hFFFF);
        write_reg(REG_SPARE_FIRST + 2'd2, 16'h5A5A);
        @(posedge clk);
        add_pixel(8'h80, 8'h7F);
        add_pixel(8'h7F, 8'h80);
        add_pixel(8'h80, 8'h80);
        add_pixel(8'h7F, 8'h7F);
        add_pixel(8'h00, 8'h01);
        add_pixel(8'h55, 8'hAA);
        drain();

        set_all(MODE_MAG_PHASE, 16'h3380, 16'hC07F, 16'h8000, 16'h7FFF);
        @(posedge clk);
        add_pixel(8'h80, 8'h00);
        add_pixel(8'h00, 8'h7F);
        add_pixel(8'hAA, 8'h55);
        add_pixel(8'h01, 8'hFF);
        drain();

        // Random sweeps: raster rows mixed with scattered pixels
        for (int sw = 0; sw < SWEEPS; sw++) begin
            gaps_on = (sw < SWEEPS - 2);
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            set_all(logic'($urandom_range(1)), pick_field(8), pick_field(8),
                    pick_field(16), pick_field(16));
            @(posedge clk);
            for (int n = 0; n < SWEEP_ITEMS; n += run_len) begin
                if ($urandom_range(2) == 0) begin
                    add_pixel(8'($urandom), 8'($urandom));
                    run_len = 1;
                end else begin
                    row     = 8'($urandom);
                    col     = 8'($urandom);
                    run_len = $urandom_range(12, 3);
                    for (int k = 0; k < run_len; k++) begin
                        add_pixel(col + k[7:0], row);
                    end
                end
            end
            drain();
        end

        repeat (PIPE_DRAIN) @(negedge clk);
        if (sample_due.size() != 0) begin
            mismatches++;
            $display("%0d samples never arrived", sample_due.size());
        end
        $display("Checked %0d of %0d pixels over %0d register writes", beats_out, beats_in,
                 cfg_writes);
        $display("Settings: %0d magnitude/phase, %0d fixed direction; %0d mismatches",
                 mode0_sweeps, mode1_sweeps, mismatches);
        if (mismatches == 0) begin
            $display("plane_wave_raster_generator_tb OK");
        end else begin
            $display("plane_wave_raster_generator_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d samples outstanding", sample_due.size());
        $display("plane_wave_raster_generator_tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
sv/pwrg_pkg.sv
sv/pwrg_phase.sv
sv/pwrg_cordic.sv
sv/plane_wave_raster_generator.sv
sim/plane_wave_raster_generator_tb.sv
